FILE: hdl/rgb_pwm_color_cycler_macros.svh
// Assertion helpers shared by the color cycler modules.
// Both forms sample on clock and are disabled while reset is high.
`ifndef RGB_PWM_COLOR_CYCLER_MACROS_SVH
`define RGB_PWM_COLOR_CYCLER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RPCC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpcc assertion failed");
// next-cycle implication
`define RPCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpcc assertion failed");
`else
`define RPCC_ASSERT_SAME(lbl, ante, cons)
`define RPCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/rpcc_pkg.sv
`timescale 1ns / 1ps
package rpcc_pkg;

   localparam int PHASE_W    = 7;
   localparam int TICK_W     = 8;
   localparam int STEP_W     = 7;
   localparam int BRIGHT_W   = 7;
   localparam int BASE_W     = 8;
   localparam int MAG_W      = BASE_W + BRIGHT_W;
   localparam int LEVEL_W    = 9;
   localparam int COLOR_W    = 8;
   localparam int NUM_CH     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [BRIGHT_W-1:0] BEAT_BRIGHTNESS  = 7'd50;
   localparam logic [STEP_W-1:0]   STEP_TICKS_RESET = 7'd100;

   // base color storage order
   localparam int BASE_G = 0;
   localparam int BASE_R = 1;
   localparam int BASE_B = 2;

   // level / pin lane order
   localparam int LANE_R = 0;
   localparam int LANE_G = 1;
   localparam int LANE_B = 2;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_BEAT   = 2'd1,
      OP_SET    = 2'd2,
      OP_TOGGLE = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHT_STEP = 1'b0,
      CSR_HUE_STEP    = 1'b1
   } csr_index_type;

   // moving base channel, rotates green -> red -> blue
   typedef enum logic [1:0] {
      CH_GREEN = 2'd0,
      CH_RED   = 2'd1,
      CH_BLUE  = 2'd2
   } base_ch_type;

   // what the level stage does with a request
   typedef enum logic [1:0] {
      LVL_HOLD  = 2'd0,
      LVL_CALC  = 2'd1,
      LVL_LOAD  = 2'd2,
      LVL_CLEAR = 2'd3
   } lvl_act_type;

   typedef struct packed {
      logic                            tick;
      lvl_act_type                     act;
      logic [PHASE_W-1:0]              phase;
      logic [NUM_CH-1:0][MAG_W-1:0]    mag;
      logic [NUM_CH-1:0]               neg;
      logic [NUM_CH-1:0][COLOR_W-1:0]  color;
   } stage_type;

endpackage

FILE: hdl/rpcc_ctrl.sv
`timescale 1ns / 1ps
`include "rgb_pwm_color_cycler_macros.svh"
module rpcc_ctrl
   import rpcc_pkg::*;
#(
   parameter int LEVELS = 80
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [COLOR_W-1:0]    req_red_level,
   input  logic [COLOR_W-1:0]    req_green_level,
   input  logic [COLOR_W-1:0]    req_blue_level,
   output logic                  stage_valid,
   output stage_type             stage_data,
   input  logic                  stage_ready
);

   localparam logic signed [BASE_W-1:0] LEVELS_BASE  = BASE_W'(LEVELS);
   localparam logic [PHASE_W-1:0]       LEVELS_PHASE = PHASE_W'(LEVELS);
   localparam logic [BRIGHT_W-1:0]      LEVELS_BRIGHT = BRIGHT_W'(LEVELS);

   logic [STEP_W-1:0]          bright_step_ff, bright_step_in;
   logic [STEP_W-1:0]          hue_step_ff, hue_step_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [TICK_W-1:0]          hue_cnt_ff, hue_cnt_in;
   logic [TICK_W-1:0]          bright_cnt_ff, bright_cnt_in;
   logic [BRIGHT_W-1:0]        brightness_ff, brightness_in;
   logic signed [BASE_W-1:0]   base_ff [NUM_CH];
   logic signed [BASE_W-1:0]   base_in [NUM_CH];
   base_ch_type                moving_ch_ff, moving_ch_in;
   logic                       moving_up_ff, moving_up_in;
   logic                       hit_ff, hit_in;
   logic                       auto_ff, auto_in;
   logic                       stage_valid_ff, stage_valid_in;
   stage_type                  stage_ff, stage_in;

   logic                       accept;
   logic [TICK_W-1:0]          hue_cnt_inc;
   logic [TICK_W-1:0]          bright_cnt_inc;
   logic                       bright_hit;
   logic                       hue_hit;
   base_ch_type                ch_next;
   logic signed [BASE_W-1:0]   stepped;

   function automatic logic [MAG_W-1:0] lane_mag(input logic signed [BASE_W-1:0] b,
                                                  input logic [BRIGHT_W-1:0] br);
      logic [BASE_W-1:0] a;
      a = b[BASE_W-1] ? BASE_W'(-b) : BASE_W'(b);
      return MAG_W'(a) * MAG_W'(br);
   endfunction

   assign req_ready   = !stage_valid_ff || stage_ready;
   assign accept      = req_valid && req_ready;
   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_ff;

   // csr writes
   always_comb begin
      bright_step_in = bright_step_ff;
      hue_step_in    = hue_step_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BRIGHT_STEP: bright_step_in = csr_data;
            CSR_HUE_STEP:    hue_step_in    = csr_data;
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      hue_cnt_in     = hue_cnt_ff;
      bright_cnt_in  = bright_cnt_ff;
      brightness_in  = brightness_ff;
      moving_ch_in   = moving_ch_ff;
      moving_up_in   = moving_up_ff;
      hit_in         = hit_ff;
      auto_in        = auto_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         base_in[c] = base_ff[c];
      end
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff && !stage_ready;

      hue_cnt_inc    = hue_cnt_ff + TICK_W'(1);
      bright_cnt_inc = bright_cnt_ff + TICK_W'(1);
      bright_hit     = auto_ff && (bright_cnt_inc == TICK_W'(bright_step_ff));
      hue_hit        = auto_ff && (hue_cnt_inc == TICK_W'(hue_step_ff));
      ch_next        = moving_ch_ff;
      stepped        = '0;

      if (accept) begin
         stage_valid_in = 1'b1;
         stage_in.tick  = 1'b0;
         stage_in.act   = LVL_HOLD;
         stage_in.phase = phase_ff;
         stage_in.color[LANE_R] = req_red_level;
         stage_in.color[LANE_G] = req_green_level;
         stage_in.color[LANE_B] = req_blue_level;

         unique case (op_type'(req_op))
            OP_TICK: begin
               stage_in.tick = 1'b1;
               hue_cnt_in    = hue_cnt_inc;
               bright_cnt_in = bright_cnt_inc;
               phase_in      = (phase_ff == LEVELS_PHASE) ? '0 : phase_ff + PHASE_W'(1);

               if (bright_hit) begin
                  brightness_in = (brightness_ff == '0) ? '0
                                                        : brightness_ff - BRIGHT_W'(1);
                  bright_cnt_in = '0;
               end

               if (hue_hit) begin
                  moving_up_in = moving_up_ff;
                  ch_next      = moving_ch_ff;
                  // a channel that ran past its limit hands over to the next one
                  if (hit_ff) begin
                     moving_up_in = !moving_up_ff;
                     unique case (moving_ch_ff)
                        CH_GREEN: ch_next = CH_RED;
                        CH_RED:   ch_next = CH_BLUE;
                        CH_BLUE:  ch_next = CH_GREEN;
                        default:  ch_next = CH_GREEN;
                     endcase
                  end
                  moving_ch_in = ch_next;
                  hit_in       = 1'b0;
                  for (int c = 0; c < NUM_CH; c++) begin
                     if (ch_next == base_ch_type'(c)) begin
                        stepped = moving_up_in ? base_ff[c] + BASE_W'(1)
                                               : base_ff[c] - BASE_W'(1);
                        base_in[c] = stepped;
                        hit_in     = moving_up_in ? (stepped > LEVELS_BASE)
                                                  : (stepped < 0);
                     end
                  end
                  hue_cnt_in = '0;
               end

               if (bright_hit || hue_hit) begin
                  stage_in.act = LVL_CALC;
               end
            end
            OP_BEAT: begin
               if (auto_ff) begin
                  brightness_in = BEAT_BRIGHTNESS;
               end else begin
                  stage_in.act = LVL_CLEAR;
               end
            end
            OP_SET: begin
               stage_in.act = LVL_LOAD;
            end
            OP_TOGGLE: begin
               auto_in = !auto_ff;
            end
         endcase

         // base * brightness split into magnitude and sign, divided downstream
         stage_in.mag[LANE_R] = lane_mag(base_in[BASE_R], brightness_in);
         stage_in.mag[LANE_G] = lane_mag(base_in[BASE_G], brightness_in);
         stage_in.mag[LANE_B] = lane_mag(base_in[BASE_B], brightness_in);
         stage_in.neg[LANE_R] = base_in[BASE_R][BASE_W-1];
         stage_in.neg[LANE_G] = base_in[BASE_G][BASE_W-1];
         stage_in.neg[LANE_B] = base_in[BASE_B][BASE_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_step_ff  <= STEP_TICKS_RESET;
         hue_step_ff     <= STEP_TICKS_RESET;
         phase_ff        <= '0;
         hue_cnt_ff      <= '0;
         bright_cnt_ff   <= '0;
         brightness_ff   <= LEVELS_BRIGHT;
         base_ff[BASE_G] <= '0;
         base_ff[BASE_R] <= LEVELS_BASE;
         base_ff[BASE_B] <= '0;
         moving_ch_ff    <= CH_GREEN;
         moving_up_ff    <= 1'b1;
         hit_ff          <= 1'b0;
         auto_ff         <= 1'b1;
         stage_valid_ff  <= 1'b0;
      end else begin
         bright_step_ff  <= bright_step_in;
         hue_step_ff     <= hue_step_in;
         phase_ff        <= phase_in;
         hue_cnt_ff      <= hue_cnt_in;
         bright_cnt_ff   <= bright_cnt_in;
         brightness_ff   <= brightness_in;
         for (int c = 0; c < NUM_CH; c++) begin
            base_ff[c] <= base_in[c];
         end
         moving_ch_ff    <= moving_ch_in;
         moving_up_ff    <= moving_up_in;
         hit_ff          <= hit_in;
         auto_ff         <= auto_in;
         stage_valid_ff  <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   `RPCC_ASSERT_SAME(a_phase_range, 1'b1, phase_ff <= LEVELS_PHASE)
   `RPCC_ASSERT_SAME(a_bright_range, 1'b1,
      (brightness_ff <= LEVELS_BRIGHT) || (brightness_ff <= BEAT_BRIGHTNESS))
   `RPCC_ASSERT_NEXT(a_tick_staged, accept && (req_op == OP_TICK),
      stage_valid_ff && stage_ff.tick)

endmodule

FILE: hdl/rpcc_pwm.sv
`timescale 1ns / 1ps
`include "rgb_pwm_color_cycler_macros.svh"
module rpcc_pwm
   import rpcc_pkg::*;
#(
   parameter int LEVELS = 80
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_valid,
   input  stage_type stage_data,
   output logic      stage_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_red_on,
   output logic      rsp_green_on,
   output logic      rsp_blue_on
);

   // divide by LEVELS as multiply by a rounded-up reciprocal; exact for any
   // magnitude below 2**MAG_W since LEVELS * 2**MAG_W < 2**DIV_SHIFT
   localparam int DIV_SHIFT = MAG_W + 7;
   localparam int RECIP     = ((1 << DIV_SHIFT) + LEVELS - 1) / LEVELS;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam logic [MAG_W-1:0] LEVEL_CAP = MAG_W'(255);

   logic signed [LEVEL_W-1:0] level_ff [NUM_CH];
   logic signed [LEVEL_W-1:0] level_in [NUM_CH];
   logic [NUM_CH-1:0]         on_ff, on_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      out_free;
   logic                      move;
   logic [PROD_W-1:0]         prod [NUM_CH];
   logic [MAG_W-1:0]          quot [NUM_CH];
   logic signed [LEVEL_W-1:0] calc [NUM_CH];

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign stage_ready = out_free || !stage_data.tick;
   assign move        = stage_valid && stage_ready;

   always_comb begin
      for (int l = 0; l < NUM_CH; l++) begin
         prod[l] = PROD_W'(stage_data.mag[l]) * PROD_W'(RECIP);
         quot[l] = MAG_W'(prod[l][PROD_W-1:DIV_SHIFT]);
         // only the compare against the phase matters: clamp to -1 .. 255
         if (stage_data.neg[l] && (quot[l] != '0)) begin
            calc[l] = '1;
         end else if (quot[l] > LEVEL_CAP) begin
            calc[l] = LEVEL_W'(LEVEL_CAP);
         end else begin
            calc[l] = LEVEL_W'(quot[l]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_CH; l++) begin
         level_in[l] = level_ff[l];
      end
      on_in = on_ff;
      if (move) begin
         for (int l = 0; l < NUM_CH; l++) begin
            unique case (stage_data.act)
               LVL_HOLD:  level_in[l] = level_ff[l];
               LVL_CALC:  level_in[l] = calc[l];
               LVL_LOAD:  level_in[l] = LEVEL_W'(stage_data.color[l]);
               LVL_CLEAR: level_in[l] = '0;
            endcase
            on_in[l] = level_in[l] >
                       $signed({{(LEVEL_W-PHASE_W){1'b0}}, stage_data.phase});
         end
      end
      rsp_valid_in = (move && stage_data.tick) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_CH; l++) begin
            level_ff[l] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int l = 0; l < NUM_CH; l++) begin
            level_ff[l] <= level_in[l];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move && stage_data.tick) begin
         on_ff <= on_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_red_on   = on_ff[LANE_R];
   assign rsp_green_on = on_ff[LANE_G];
   assign rsp_blue_on  = on_ff[LANE_B];

   `RPCC_ASSERT_SAME(a_level_floor, 1'b1,
      (level_ff[LANE_R] >= -1) && (level_ff[LANE_G] >= -1) && (level_ff[LANE_B] >= -1))
   `RPCC_ASSERT_NEXT(a_tick_to_rsp, move && stage_data.tick, rsp_valid_ff)
   `RPCC_ASSERT_SAME(a_stall_blocks, stage_data.tick && rsp_valid_ff && !rsp_ready,
      !stage_ready)

endmodule

FILE: hdl/rgb_pwm_color_cycler.sv
`timescale 1ns / 1ps
// RGB PWM color cycler.
// req_ channel: one request per cycle carries req_op (tick, beat, set color,
//   toggle auto mode) plus three 8-bit levels used by set color.
// rsp_ channel: every tick request returns one response with the three pin
//   drives red/green/blue_on; the other ops update state and return nothing.
// csr_ channel: csr_index 0 writes the brightness step tick count, 1 the hue
//   step tick count; csr_ready is always high. Write only while idle.
// Path: a tick accepted on req_ passes the control register stage, then
//   divide/compare into the response register, before it shows on rsp_.
// Throughput: one request per cycle if req_ready is high. Back-to-back ticks
//   are sustained while rsp_ready stays high; the rate is set by the single
//   control stage that owns the tick counters, base color walk and PWM phase.
// Stall: with rsp_ready low the pending response holds; non-tick requests
//   still pass, the next tick parks in the control stage, then req_ready
//   drops until the response goes.
// Reset (synchronous): phase and counters 0, brightness LEVELS, base color
//   red only, auto mode on, levels 0, both step counts 100, no response.
module rgb_pwm_color_cycler
   import rpcc_pkg::*;
#(
   parameter int LEVELS = 80
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [COLOR_W-1:0]    req_red_level,
   input  logic [COLOR_W-1:0]    req_green_level,
   input  logic [COLOR_W-1:0]    req_blue_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_red_on,
   output logic                  rsp_green_on,
   output logic                  rsp_blue_on
);

   logic      stage_valid;
   logic      stage_ready;
   stage_type stage_data;

   // registers are plain flops, a write always lands
   assign csr_ready = 1'b1;

   // control stage: counters, brightness decay, hue walk, products
   rpcc_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .stage_valid     (stage_valid),
      .stage_data      (stage_data),
      .stage_ready     (stage_ready)
   );

   // level stage: divide by LEVELS, hold levels, compare with phase
   rpcc_pwm #(
      .LEVELS (LEVELS)
   ) u_pwm (
      .clock        (clock),
      .reset        (reset),
      .stage_valid  (stage_valid),
      .stage_data   (stage_data),
      .stage_ready  (stage_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_red_on   (rsp_red_on),
      .rsp_green_on (rsp_green_on),
      .rsp_blue_on  (rsp_blue_on)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import rpcc_pkg::*;

   localparam int CYC_LEVELS = 80;
   // a tick passes the control stage and the response register before rsp_; allow margin
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DIR_ROWS = 24;
   localparam int NUM_PHASES = 6;

   typedef struct packed {
      logic red_on;
      logic green_on;
      logic blue_on;
   } pin_set_t;

   // one directed request; pins are typed in only where known is set
   typedef struct {
      op_type     op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         known;
      pin_set_t   pins;
   } stim_row_t;

   // step thresholds and request count for one random phase
   typedef struct {
      bit [6:0] bright_steps;
      bit [6:0] hue_steps;
      int       items;
   } phase_plan_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_op;
   logic [COLOR_W-1:0]    req_red_level;
   logic [COLOR_W-1:0]    req_green_level;
   logic [COLOR_W-1:0]    req_blue_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_red_on;
   logic                  rsp_green_on;
   logic                  rsp_blue_on;

   rgb_pwm_color_cycler #(
      .LEVELS(CYC_LEVELS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_on      (rsp_red_on),
      .rsp_green_on    (rsp_green_on),
      .rsp_blue_on     (rsp_blue_on)
   );

   // ---------------------------------------------------------------
   // Color cycler shadow state, kept in step with accepted requests.
   // ---------------------------------------------------------------
   bit [6:0]    bright_step_m = STEP_TICKS_RESET;
   bit [6:0]    hue_step_m    = STEP_TICKS_RESET;
   int          phase_m       = 0;
   bit [7:0]    hue_cnt_m     = '0;
   bit [7:0]    bright_cnt_m  = '0;
   int          bright_m      = CYC_LEVELS;
   // base color is stored green, red, blue; levels red, green, blue
   int          base_m [NUM_CH] = '{0, CYC_LEVELS, 0};
   int          lvl_m  [NUM_CH] = '{0, 0, 0};
   base_ch_type mov_ch_m      = CH_GREEN;
   bit          mov_up_m      = 1'b1;
   bit          at_limit_m    = 1'b0;
   bit          auto_on_m     = 1'b1;

   // pin sets owed by the block, oldest first
   pin_set_t pins_due [$];
   int       mismatch_count = 0;
   int       cycle_count = 0;
   int       sender_calm = 0;

   stim_row_t   dir_rows [DIR_ROWS];
   phase_plan_t plan [NUM_PHASES];

   // base stays an 8-bit two's complement value
   function automatic int wrap_byte(input int v);
      byte b;
      b = byte'(v);
      return int'(b);
   endfunction

   // levels = base * brightness / LEVELS, truncated toward zero
   function automatic void refresh_levels();
      lvl_m[LANE_R] = (base_m[BASE_R] * bright_m) / CYC_LEVELS;
      lvl_m[LANE_G] = (base_m[BASE_G] * bright_m) / CYC_LEVELS;
      lvl_m[LANE_B] = (base_m[BASE_B] * bright_m) / CYC_LEVELS;
   endfunction

   // Apply one request to the shadow state; returns 1 when a tick
   // produces a pin set.
   function automatic bit cycler_step(input op_type op, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue,
                                      output pin_set_t pins);
      int ch;
      pins = '0;
      case (op)
         OP_BEAT: begin
            if (auto_on_m) begin
               bright_m = int'(BEAT_BRIGHTNESS);
            end else begin
               lvl_m = '{0, 0, 0};
            end
            return 1'b0;
         end
         OP_SET: begin
            lvl_m[LANE_R] = int'(red);
            lvl_m[LANE_G] = int'(green);
            lvl_m[LANE_B] = int'(blue);
            return 1'b0;
         end
         OP_TOGGLE: begin
            auto_on_m = !auto_on_m;
            return 1'b0;
         end
         default: ;
      endcase

      hue_cnt_m++;
      bright_cnt_m++;
      if (auto_on_m) begin
         if (bright_cnt_m == {1'b0, bright_step_m}) begin
            if (bright_m > 0) bright_m--;
            refresh_levels();
            bright_cnt_m = '0;
         end
         if (hue_cnt_m == {1'b0, hue_step_m}) begin
            if (at_limit_m) begin
               case (mov_ch_m)
                  CH_GREEN: mov_ch_m = CH_RED;
                  CH_RED:   mov_ch_m = CH_BLUE;
                  default:  mov_ch_m = CH_GREEN;
               endcase
               mov_up_m = !mov_up_m;
               at_limit_m = 1'b0;
            end
            ch = int'(mov_ch_m);
            if (mov_up_m) begin
               base_m[ch] = wrap_byte(base_m[ch] + 1);
               if (base_m[ch] > CYC_LEVELS) at_limit_m = 1'b1;
            end else begin
               base_m[ch] = wrap_byte(base_m[ch] - 1);
               if (base_m[ch] < 0) at_limit_m = 1'b1;
            end
            refresh_levels();
            hue_cnt_m = '0;
         end
      end

      // pins use the phase before it advances; a level of -1 stays off
      pins.red_on   = lvl_m[LANE_R] > phase_m;
      pins.green_on = lvl_m[LANE_G] > phase_m;
      pins.blue_on  = lvl_m[LANE_B] > phase_m;
      phase_m = (phase_m >= CYC_LEVELS) ? 0 : phase_m + 1;
      return 1'b1;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 93) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // small levels land near the phase range, the rest cover all bits
   function automatic logic [7:0] pick_level();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, CYC_LEVELS + 2));
      return 8'($urandom_range(0, 255));
   endfunction

   // Ticks dominate. Manual mode is left again quickly so the color
   // walk keeps running for most of the run.
   function automatic op_type pick_op();
      int unsigned roll;
      int unsigned toggle_cut;
      roll = $urandom_range(0, 99);
      toggle_cut = auto_on_m ? 2 : 15;
      if (roll < toggle_cut) return OP_TOGGLE;
      if (roll < toggle_cut + 4) return OP_BEAT;
      if (roll < toggle_cut + 10) return OP_SET;
      return OP_TICK;
   endfunction

   // ---------------------------------------------------------------
   // Request side. Valid stays high from one request to the next
   // unless a gap or a drain lowers it.
   // ---------------------------------------------------------------
   task automatic send_request(input op_type op, input logic [7:0] red,
                               input logic [7:0] green, input logic [7:0] blue,
                               input bit known, input pin_set_t known_pins);
      pin_set_t pins;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_red_level   <= red;
      req_green_level <= green;
      req_blue_level  <= blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cycler_step(op, red, green, blue, pins))
         pins_due.push_back(known ? known_pins : pins);
   endtask

   task automatic idle_for(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every owed pin set has come back
   task automatic drain_rsp();
      req_valid <= 1'b0;
      do @(posedge clock); while (pins_due.size() != 0);
   endtask

   // called right after each accepted request
   task automatic pace_sender();
      int unsigned roll;
      if (sender_calm > 0) begin
         sender_calm--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll == 0) begin
            drain_rsp();
         end else if (roll < 3) begin
            sender_calm = $urandom_range(40, 150);
         end else if (roll < 35) begin
            idle_for(gap_len());
         end
      end
   endtask

   // Both step thresholds, back to back, only while the block is idle.
   task automatic program_steps(input bit [6:0] bright_steps, input bit [6:0] hue_steps);
      drain_rsp();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_BRIGHT_STEP;
      csr_data  <= bright_steps;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      bright_step_m = bright_steps;
      csr_index <= CSR_HUE_STEP;
      csr_data  <= hue_steps;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      hue_step_m = hue_steps;
      csr_valid <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, with calm stretches of no stalls.
   initial begin : rsp_sink
      int          hold;
      int          calm;
      int unsigned roll;
      hold = 0;
      calm = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (calm > 0) begin
            calm--;
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3) calm = $urandom_range(100, 300);
            else if (roll < 30) hold = gap_len();
         end
      end
   end

   // Every accepted response is matched against the oldest owed pin set.
   always @(posedge clock) begin : rsp_check
      pin_set_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pins_due.size() == 0) begin
            $display("%0t: response with nothing owed, got r%0b g%0b b%0b",
                     $time, rsp_red_on, rsp_green_on, rsp_blue_on);
            mismatch_count++;
         end else begin
            want = pins_due.pop_front();
            if (rsp_red_on !== want.red_on) begin
               $display("%0t: red_on expected %0b actual %0b",
                        $time, want.red_on, rsp_red_on);
               mismatch_count++;
            end
            if (rsp_green_on !== want.green_on) begin
               $display("%0t: green_on expected %0b actual %0b",
                        $time, want.green_on, rsp_green_on);
               mismatch_count++;
            end
            if (rsp_blue_on !== want.blue_on) begin
               $display("%0t: blue_on expected %0b actual %0b",
                        $time, want.blue_on, rsp_blue_on);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      op_type   op;
      pin_set_t no_pins;
      no_pins = '0;

      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = CSR_BRIGHT_STEP;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_op          = OP_TICK;
      req_red_level   = '0;
      req_green_level = '0;
      req_blue_level  = '0;

      // Directed part, reset thresholds (100) so no step fires here.
      // Pins read straight off the levels against phases 0..7; the
      // rows from the toggle back to auto onward go through the shadow model.
      dir_rows = '{
         '{OP_TICK,   8'hff, 8'h00, 8'hff, 1'b1, 3'b000}, // reset levels are 0
         '{OP_SET,    8'hff, 8'hff, 8'hff, 1'b0, 3'b000},
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b111}, // 255 beats phase 1
         '{OP_SET,    8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_TICK,   8'h55, 8'haa, 8'h55, 1'b1, 3'b000},
         '{OP_SET,    8'h03, 8'h00, 8'hff, 1'b0, 3'b000},
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b001}, // level equal to phase: off
         '{OP_BEAT,   8'hff, 8'hff, 8'hff, 1'b0, 3'b000}, // auto beat, no recompute
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b001},
         '{OP_TOGGLE, 8'h00, 8'h00, 8'h00, 1'b0, 3'b000}, // to manual
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b001},
         '{OP_BEAT,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000}, // manual beat clears levels
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
         '{OP_SET,    8'h80, 8'h7f, 8'h01, 1'b0, 3'b000},
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
         '{OP_SET,    8'haa, 8'h55, 8'hff, 1'b0, 3'b000},
         '{OP_TOGGLE, 8'hff, 8'hff, 8'hff, 1'b0, 3'b000}, // back to auto
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_BEAT,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_TOGGLE, 8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_TOGGLE, 8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
         '{OP_TICK,   8'hff, 8'hff, 8'hff, 1'b0, 3'b000}
      };

      // Zero thresholds only match when the counter wraps. A threshold
      // of 1 steps on every tick and drives the hue walk around the
      // wheel, down to a base of -1 and up past LEVELS. The last phase
      // is random.
      plan = '{
         '{7'd0,   7'd1,   300},
         '{7'd1,   7'd0,   100},
         '{7'd127, 7'd127, 100},
         '{7'd1,   7'd1,   150},
         '{7'd2,   7'd3,   100},
         '{7'd0,   7'd0,   100}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].op, dir_rows[i].red, dir_rows[i].green,
                      dir_rows[i].blue, dir_rows[i].known,
                      dir_rows[i].known ? dir_rows[i].pins : no_pins);
         pace_sender();
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1) begin
            plan[p].bright_steps = 7'($urandom_range(0, 127));
            plan[p].hue_steps    = 7'($urandom_range(0, 127));
         end
         program_steps(plan[p].bright_steps, plan[p].hue_steps);
         sender_calm = ($urandom_range(0, 1) == 0) ? $urandom_range(20, 60) : 0;
         repeat (plan[p].items) begin
            op = pick_op();
            send_request(op, pick_level(), pick_level(), pick_level(), 1'b0, no_pins);
            pace_sender();
         end
      end

      drain_rsp();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatch_count == 0 && pins_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
